[sv/bpd_pkg.sv]
package bpd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned TICK_W     = 17;
	localparam int unsigned TIMEOUT_W  = 16;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [BYTE_W-1:0]    START_BYTE    = 8'hfe;
	localparam logic [BYTE_W-1:0]    END_BYTE      = 8'hff;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

	// register index is paddr[2]; only one register exists
	localparam logic REG_TIMEOUT = 1'b0;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_LEN  = 3'd1,
		PH_TYPE = 3'd2,
		PH_BODY = 3'd3,
		PH_TERM = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		EV_HEADER  = 3'd0,
		EV_BYTE    = 3'd1,
		EV_GOOD    = 3'd2,
		EV_BADTERM = 3'd3,
		EV_TIMEOUT = 3'd4
	} event_t;

	typedef struct packed {
		logic              cmd;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

	typedef struct packed {
		event_t            ev;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] msg_type;
		logic [BYTE_W-1:0] frame_length;
	} result_t;

endpackage

[sv/byte_packet_deframer.sv]
// A beat accepted into the input register gives its result (if any) at out_valid via the result register.
// Throughput: one byte or tick beat per cycle unless out_stall holds a full result register;
// the frame FSM updates once per beat. in_stall rises only while the result register is held by out_stall and the
// input register is full.
// Reset (arst_n low, asynchronous): FSM idle, header and tick state cleared,
// both pipeline stages empty, timeout_ticks back to 1000.
module byte_packet_deframer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd,
	input  logic [bpd_pkg::BYTE_W-1:0]       rx_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       event_res,
	output logic [bpd_pkg::BYTE_W-1:0]       data,
	output logic [bpd_pkg::BYTE_W-1:0]       msg_type,
	output logic [bpd_pkg::BYTE_W-1:0]       frame_length,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bpd_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [bpd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [bpd_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);

	logic [bpd_pkg::TIMEOUT_W-1:0] timeout_ticks;
	logic                          take;
	logic                          item_valid;
	bpd_pkg::item_t                item;
	bpd_pkg::result_t              result;

	bpd_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_ticks (timeout_ticks)
	);

	bpd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.rx_byte    (rx_byte),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	bpd_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item          (item),
		.timeout_ticks (timeout_ticks),
		.take          (take),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.result        (result)
	);

	assign event_res    = result.ev;
	assign data         = result.data;
	assign msg_type     = result.msg_type;
	assign frame_length = result.frame_length;

endmodule

[sv/bpd_regs.sv]
module bpd_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bpd_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [bpd_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [bpd_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	output logic [bpd_pkg::TIMEOUT_W-1:0]       timeout_ticks
);

	logic [bpd_pkg::TIMEOUT_W-1:0] timeout_q;
	logic                          wr_en;
	logic                          sel_timeout;

	assign pready      = 1'b1;
	assign sel_timeout = (paddr[2] == bpd_pkg::REG_TIMEOUT);
	assign wr_en       = psel && penable && pwrite && pready && sel_timeout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= bpd_pkg::TIMEOUT_RESET;
		end else if (wr_en) begin
			timeout_q <= pwdata[bpd_pkg::TIMEOUT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_timeout) begin
			prdata = {{(bpd_pkg::APB_DATA_W - bpd_pkg::TIMEOUT_W){1'b0}}, timeout_q};
		end
	end

	assign timeout_ticks = timeout_q;

endmodule

[sv/bpd_in_stage.sv]
module bpd_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [bpd_pkg::BYTE_W-1:0]    rx_byte,
	input  logic                          take,
	output logic                          item_valid,
	output bpd_pkg::item_t                item
);

	logic           valid_s1;
	bpd_pkg::item_t item_s1;
	logic           load;

	// full stage frees up in the same cycle the FSM takes its beat
	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.cmd     <= cmd;
			item_s1.rx_byte <= rx_byte;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

[sv/bpd_fsm.sv]
module bpd_fsm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  bpd_pkg::item_t                   item,
	input  logic [bpd_pkg::TIMEOUT_W-1:0]    timeout_ticks,
	output logic                             take,
	input  logic                             out_stall,
	output logic                             out_valid,
	output bpd_pkg::result_t                 result
);

	bpd_pkg::phase_t               phase_q, phase_d;
	logic [bpd_pkg::BYTE_W-1:0]    len_q, len_d;
	logic [bpd_pkg::BYTE_W-1:0]    type_q, type_d;
	logic [bpd_pkg::BYTE_W-1:0]    rem_q, rem_d;
	logic [bpd_pkg::TICK_W-1:0]    ticks_q, ticks_d;
	logic [bpd_pkg::TICK_W-1:0]    ticks_inc;
	logic                          timed_out;
	logic [bpd_pkg::BYTE_W-1:0]    rem_dec;

	logic                          has_res;
	bpd_pkg::event_t               ev;
	logic [bpd_pkg::BYTE_W-1:0]    res_data;

	logic                          valid_s2;
	bpd_pkg::result_t              res_s2;
	logic                          out_free;

	assign out_free = !valid_s2 || !out_stall;
	assign take     = item_valid && out_free;

	// saturating tick count, compared after the increment
	assign ticks_inc = (ticks_q == {bpd_pkg::TICK_W{1'b1}}) ? ticks_q
	                 : ticks_q + bpd_pkg::TICK_W'(1);
	assign timed_out = ticks_inc > {1'b0, timeout_ticks};
	assign rem_dec   = rem_q - bpd_pkg::BYTE_W'(1);

	// next state
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		type_d  = type_q;
		rem_d   = rem_q;
		ticks_d = ticks_q;
		if (item.cmd == bpd_pkg::CMD_TICK) begin
			if (phase_q != bpd_pkg::PH_IDLE) begin
				ticks_d = ticks_inc;
				if (timed_out) begin
					phase_d = bpd_pkg::PH_IDLE;
				end
			end
		end else begin
			unique case (phase_q)
				bpd_pkg::PH_LEN: begin
					len_d   = item.rx_byte;
					phase_d = bpd_pkg::PH_TYPE;
				end
				bpd_pkg::PH_TYPE: begin
					type_d  = item.rx_byte;
					rem_d   = len_q;
					phase_d = (len_q == '0) ? bpd_pkg::PH_TERM : bpd_pkg::PH_BODY;
				end
				bpd_pkg::PH_BODY: begin
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						phase_d = bpd_pkg::PH_TERM;
					end
				end
				bpd_pkg::PH_TERM: begin
					phase_d = bpd_pkg::PH_IDLE;
				end
				default: begin
					phase_d = bpd_pkg::PH_IDLE;
					if (item.rx_byte == bpd_pkg::START_BYTE) begin
						ticks_d = '0;
						len_d   = '0;
						type_d  = '0;
						rem_d   = '0;
						phase_d = bpd_pkg::PH_LEN;
					end
				end
			endcase
		end
	end

	// result of this beat
	always_comb begin
		has_res  = 1'b0;
		ev       = bpd_pkg::EV_HEADER;
		res_data = '0;
		if (item.cmd == bpd_pkg::CMD_TICK) begin
			if (phase_q != bpd_pkg::PH_IDLE && timed_out) begin
				has_res = 1'b1;
				ev      = bpd_pkg::EV_TIMEOUT;
			end
		end else begin
			unique case (phase_q)
				bpd_pkg::PH_TYPE: begin
					has_res = 1'b1;
					ev      = bpd_pkg::EV_HEADER;
				end
				bpd_pkg::PH_BODY: begin
					has_res  = 1'b1;
					ev       = bpd_pkg::EV_BYTE;
					res_data = item.rx_byte;
				end
				bpd_pkg::PH_TERM: begin
					has_res = 1'b1;
					ev      = (item.rx_byte == bpd_pkg::END_BYTE) ? bpd_pkg::EV_GOOD
					        : bpd_pkg::EV_BADTERM;
				end
				default: begin
					has_res = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bpd_pkg::PH_IDLE;
			len_q   <= '0;
			type_q  <= '0;
			rem_q   <= '0;
			ticks_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			type_q  <= type_d;
			rem_q   <= rem_d;
			ticks_q <= ticks_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= take && has_res;
		end
	end

	// header shows the type byte just taken, hence the next-state values
	always_ff @(posedge clk) begin
		if (take && has_res) begin
			res_s2.ev           <= ev;
			res_s2.data         <= res_data;
			res_s2.msg_type     <= type_d;
			res_s2.frame_length <= len_d;
		end
	end

	assign out_valid = valid_s2;
	assign result    = res_s2;

endmodule

[sv/bpd_chk.sv]
module bpd_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             cmd,
	input logic [bpd_pkg::BYTE_W-1:0]       rx_byte,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [2:0]                       event_res,
	input logic [bpd_pkg::BYTE_W-1:0]       data,
	input logic [bpd_pkg::BYTE_W-1:0]       msg_type,
	input logic [bpd_pkg::BYTE_W-1:0]       frame_length,
	input logic                             psel,
	input logic                             penable,
	input logic                             pwrite,
	input logic [bpd_pkg::APB_ADDR_W-1:0]   paddr,
	input logic [bpd_pkg::APB_DATA_W-1:0]   pwdata,
	input logic [bpd_pkg::APB_DATA_W-1:0]   prdata,
	input logic                             pready
);

	// input backs up only behind a held result
	a_stall_needs_backup: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("in_stall high with empty result register");

	// data carries a byte only on payload beats
	a_data_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res != bpd_pkg::EV_BYTE) |-> (data == '0))
		else $error("nonzero data on non-payload result");

	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(event_res) && $stable(data)
			&& $stable(msg_type) && $stable(frame_length))
		else $error("result changed while stalled");

endmodule

bind byte_packet_deframer bpd_chk u_chk (.*);

[dv/tb_byte_packet_deframer.sv]
module tb_byte_packet_deframer;
	import bpd_pkg::*;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_TYPED,
		ROW_CFG
	} row_kind_t;

	// ROW_CFG rows carry the new timeout in b
	typedef struct {
		row_kind_t         kind;
		logic              c;
		logic [BYTE_W-1:0] b;
		bit                has;
		result_t           res;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  cmd = CMD_BYTE;
	logic [BYTE_W-1:0]     rx_byte = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            event_res;
	logic [BYTE_W-1:0]     data;
	logic [BYTE_W-1:0]     msg_type;
	logic [BYTE_W-1:0]     frame_length;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	byte_packet_deframer dut (.*);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// deframer state mirror
	phase_t                fr_phase = PH_IDLE;
	logic [BYTE_W-1:0]     hdr_len = '0;
	logic [BYTE_W-1:0]     hdr_type = '0;
	logic [BYTE_W-1:0]     body_left = '0;
	logic [TICK_W-1:0]     tick_count = '0;
	logic [TIMEOUT_W-1:0]  limit_ticks = TIMEOUT_RESET;

	result_t               pending_events[$];
	dir_row_t              dir_rows[$];

	// expectation pinned by a directed row, sampled with the beat
	bit                    pin_on = 1'b0;
	bit                    pin_has = 1'b0;
	result_t               pin_res = '0;

	int                    tick_pct = 0;
	int                    in_gap_pct = 0;
	int                    stall_pct = 0;
	int                    stall_left = 0;
	int unsigned           mismatches = 0;
	int unsigned           live_beats = 0;
	int unsigned           in_beats = 0;
	int unsigned           ev_count[5] = '{default: 0};
	logic [TIMEOUT_W-1:0]  rand_to;

	function automatic result_t frame_event(event_t ev, logic [BYTE_W-1:0] d);
		result_t r;
		r.ev = ev;
		r.data = d;
		r.msg_type = hdr_type;
		r.frame_length = hdr_len;
		return r;
	endfunction

	function automatic bit deframe_step(input logic c, input logic [BYTE_W-1:0] b,
		output result_t r);
		r = '0;
		if (c == CMD_TICK) begin
			if (fr_phase == PH_IDLE)
				return 1'b0;
			if (tick_count != '1)
				tick_count++;
			// counted first, then compared
			if (tick_count > {1'b0, limit_ticks}) begin
				fr_phase = PH_IDLE;
				r = frame_event(EV_TIMEOUT, '0);
				return 1'b1;
			end
			return 1'b0;
		end
		case (fr_phase)
			PH_IDLE: begin
				if (b == START_BYTE) begin
					tick_count = '0;
					hdr_len = '0;
					hdr_type = '0;
					body_left = '0;
					fr_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				hdr_len = b;
				fr_phase = PH_TYPE;
			end
			PH_TYPE: begin
				hdr_type = b;
				body_left = hdr_len;
				if (hdr_len == 0)
					fr_phase = PH_TERM;
				else
					fr_phase = PH_BODY;
				r = frame_event(EV_HEADER, '0);
				return 1'b1;
			end
			PH_BODY: begin
				body_left--;
				if (body_left == 0)
					fr_phase = PH_TERM;
				r = frame_event(EV_BYTE, b);
				return 1'b1;
			end
			default: begin
				fr_phase = PH_IDLE;
				if (b == END_BYTE)
					r = frame_event(EV_GOOD, '0);
				else
					r = frame_event(EV_BADTERM, '0);
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic dir_row_t dir_row(row_kind_t kind, logic c, logic [BYTE_W-1:0] b,
		bit has = 1'b0, event_t ev = EV_HEADER, logic [BYTE_W-1:0] d = '0,
		logic [BYTE_W-1:0] t = '0, logic [BYTE_W-1:0] l = '0);
		dir_row_t row;
		row.kind = kind;
		row.c = c;
		row.b = b;
		row.has = has;
		row.res.ev = ev;
		row.res.data = d;
		row.res.msg_type = t;
		row.res.frame_length = l;
		return row;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	task automatic report(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			out_stall = 1'b0;
			stall_left = pick_gap(stall_pct);
		end
	end

	always @(posedge clk) begin : scoreboard
		result_t exp_r;
		result_t got;
		bit      has;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.ev = event_t'(event_res);
				got.data = data;
				got.msg_type = msg_type;
				got.frame_length = frame_length;
				if (pending_events.size() == 0) begin
					report($sformatf("unexpected result ev=%0d data=%02h type=%02h len=%02h",
						event_res, data, msg_type, frame_length));
				end else begin
					exp_r = pending_events.pop_front();
					ev_count[int'(exp_r.ev)]++;
					if (got !== exp_r)
						report($sformatf({"result mismatch: expected ev=%0d data=%02h ",
							"type=%02h len=%02h, got ev=%0d data=%02h type=%02h len=%02h"},
							exp_r.ev, exp_r.data, exp_r.msg_type, exp_r.frame_length,
							event_res, data, msg_type, frame_length));
				end
			end
			if (in_valid && !in_stall) begin
				in_beats++;
				if (fr_phase != PH_IDLE || (cmd == CMD_BYTE && rx_byte == START_BYTE))
					live_beats++;
				has = deframe_step(cmd, rx_byte, exp_r);
				if (pin_on) begin
					has = pin_has;
					exp_r = pin_res;
				end
				if (has)
					pending_events.push_back(exp_r);
			end
		end
	end

	task automatic send_beat(input logic c, input logic [BYTE_W-1:0] b,
		input bit pinned = 1'b0, input bit has = 1'b0, input result_t res = '0);
		int gap;
		gap = pick_gap(in_gap_pct);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		cmd = c;
		rx_byte = b;
		pin_on = pinned;
		pin_has = has;
		pin_res = res;
		do @(posedge clk); while (in_stall);
	endtask

	// ticks may land between any two bytes
	task automatic send_data(input logic [BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < tick_pct)
			send_beat(CMD_TICK, 8'($urandom));
		send_beat(CMD_BYTE, b);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		pin_on = 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic read_timeout(input logic [TIMEOUT_W-1:0] expv);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = {REG_TIMEOUT, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_W'(expv))
			report($sformatf("timeout readback: expected %0d, got %0d", expv, prdata));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_timeout(input logic [TIMEOUT_W-1:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {REG_TIMEOUT, 2'b00};
		pwdata = APB_DATA_W'(v);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		limit_ticks = v;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		read_timeout(v);
	endtask

	task automatic random_frame();
		logic [BYTE_W-1:0] len;
		int sel;
		sel = $urandom_range(0, 39);
		if (sel == 0)
			len = BYTE_W'($urandom_range(128, 255));
		else if (sel < 6)
			len = '0;
		else
			len = BYTE_W'($urandom_range(1, 12));
		send_data(START_BYTE);
		send_data(len);
		send_data(8'($urandom));
		repeat (len) begin
			sel = $urandom_range(0, 15);
			if (sel == 0)
				send_data(START_BYTE);
			else if (sel == 1)
				send_data(END_BYTE);
			else
				send_data(8'($urandom));
		end
		if ($urandom_range(0, 99) < 85)
			send_data(END_BYTE);
		else
			send_data(8'($urandom));
	endtask

	task automatic run_phase(input logic [TIMEOUT_W-1:0] to, input int tpct,
		input int gpct, input int spct, input int beats);
		int unsigned target;
		int sel;
		settle();
		set_timeout(to);
		tick_pct = tpct;
		in_gap_pct = gpct;
		stall_pct = spct;
		target = in_beats + beats;
		while (in_beats < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				random_frame();
			end else if (sel < 87) begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 3) == 0)
						send_beat(CMD_TICK, 8'($urandom));
					else
						send_beat(CMD_BYTE, 8'($urandom));
				end
			end else begin
				// truncated frame, then a burst of ticks
				send_data(START_BYTE);
				repeat ($urandom_range(0, 4)) send_data(8'($urandom));
				repeat ($urandom_range(0, 12)) send_beat(CMD_TICK, 8'($urandom));
			end
		end
	endtask

	initial begin
		dir_rows = '{
			dir_row(ROW_TYPED, CMD_BYTE, 8'h00),
			dir_row(ROW_TYPED, CMD_TICK, 8'h5a),
			dir_row(ROW_TYPED, CMD_BYTE, END_BYTE),
			dir_row(ROW_PREDICT, CMD_BYTE, START_BYTE),
			dir_row(ROW_PREDICT, CMD_BYTE, 8'h02),
			dir_row(ROW_TYPED, CMD_BYTE, 8'h00, 1'b1, EV_HEADER, 8'h00, 8'h00, 8'h02),
			dir_row(ROW_TYPED, CMD_BYTE, 8'hff, 1'b1, EV_BYTE, 8'hff, 8'h00, 8'h02),
			dir_row(ROW_PREDICT, CMD_BYTE, START_BYTE),
			dir_row(ROW_TYPED, CMD_BYTE, END_BYTE, 1'b1, EV_GOOD, 8'h00, 8'h00, 8'h02),
			dir_row(ROW_PREDICT, CMD_BYTE, START_BYTE),
			dir_row(ROW_PREDICT, CMD_BYTE, 8'h00),
			dir_row(ROW_TYPED, CMD_BYTE, 8'hff, 1'b1, EV_HEADER, 8'h00, 8'hff, 8'h00),
			dir_row(ROW_TYPED, CMD_BYTE, 8'h00, 1'b1, EV_BADTERM, 8'h00, 8'hff, 8'h00),
			dir_row(ROW_CFG, CMD_BYTE, 8'd0),
			dir_row(ROW_PREDICT, CMD_BYTE, START_BYTE),
			dir_row(ROW_TYPED, CMD_TICK, 8'hff, 1'b1, EV_TIMEOUT, 8'h00, 8'h00, 8'h00),
			dir_row(ROW_PREDICT, CMD_BYTE, START_BYTE),
			dir_row(ROW_PREDICT, CMD_BYTE, 8'hff),
			dir_row(ROW_TYPED, CMD_TICK, 8'h00, 1'b1, EV_TIMEOUT, 8'h00, 8'h00, 8'hff),
			dir_row(ROW_CFG, CMD_BYTE, 8'd1),
			dir_row(ROW_PREDICT, CMD_BYTE, START_BYTE),
			dir_row(ROW_PREDICT, CMD_BYTE, 8'h80),
			dir_row(ROW_PREDICT, CMD_BYTE, 8'h7f),
			dir_row(ROW_PREDICT, CMD_TICK, 8'h01),
			dir_row(ROW_PREDICT, CMD_BYTE, 8'h01),
			dir_row(ROW_TYPED, CMD_TICK, 8'h80, 1'b1, EV_TIMEOUT, 8'h00, 8'h7f, 8'h80)
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		read_timeout(TIMEOUT_RESET);

		in_gap_pct = 30;
		stall_pct = 30;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				settle();
				set_timeout(TIMEOUT_W'(dir_rows[i].b));
			end else begin
				send_beat(dir_rows[i].c, dir_rows[i].b, dir_rows[i].kind == ROW_TYPED,
					dir_rows[i].has, dir_rows[i].res);
			end
		end

		run_phase(16'd2, 15, 30, 30, 180);
		run_phase('1, 30, 30, 30, 180);
		run_phase(16'd10, 10, 0, 0, 180);
		run_phase(16'd0, 3, 50, 50, 180);
		rand_to = TIMEOUT_W'($urandom_range(1, 40));
		run_phase(rand_to, 8, 30, 60, 180);
		run_phase(TIMEOUT_RESET, 5, 20, 20, 180);

		settle();
		if (pending_events.size() != 0)
			report($sformatf("%0d results never arrived", pending_events.size()));

		$display("Sent %0d beats, %0d inside frames: %0d headers, %0d payload,",
			in_beats, live_beats, ev_count[EV_HEADER], ev_count[EV_BYTE]);
		$display("%0d good, %0d bad end, %0d timeouts; timeouts tried: 0, 1, 2, 10, %0d, %s",
			ev_count[EV_GOOD], ev_count[EV_BADTERM], ev_count[EV_TIMEOUT], rand_to,
			$sformatf("1000, 65535; %0d mismatches", mismatches));
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
